[sv/chm_pkg.sv]
package chm_pkg;

  // Table sizes; BUCKETS is a power of two, so the bucket is the low key bits
  localparam int BUCKETS    = 256;
  localparam int ENTRIES    = 1024;
  localparam int KEY_WIDTH  = 32;
  localparam int DATA_WIDTH = 32;

  // Derived widths
  localparam int BKT_W = $clog2(BUCKETS);
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Fixed result field widths
  localparam int OUT_VAL_W  = 32;
  localparam int ENT_USED_W = 11;

  // Operation codes
  localparam logic CMD_FIND = 1'b0;
  localparam logic CMD_PUT  = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [KEY_WIDTH-1:0]  key;
    logic [DATA_WIDTH-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic                  found;
    logic [OUT_VAL_W-1:0]  value_out;
    logic                  inserted;
    logic                  pool_full;
    logic [ENT_USED_W-1:0] entries_used;
  } out_item_t;

  // Bucket head word: chain present flag and head entry index
  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
  } head_t;

  // Pool entry word: key, data and link to the next older entry
  typedef struct packed {
    logic [KEY_WIDTH-1:0]  key;
    logic [DATA_WIDTH-1:0] value;
    logic                  link_ok;
    logic [IDX_W-1:0]      link;
  } entry_t;

endpackage

[sv/chm_ram.sv]
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, register one read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/chained_hash_map_top.sv]
// Channel  Direction  Payload            Handshake
// in_      input      chm_pkg::in_item_t  in_valid / in_stall
// out_     output     chm_pkg::out_item_t out_valid / out_stall
//
// An item passes through accept, bucket head read, one entry memory read per
// chain entry visited, and result hand-off; the next item waits until then.
// The chain walk reads the entry memory through its single read port.
// After reset a clearing pass writes every bucket head (BUCKETS, 256),
// during which no item is accepted.
// A result waiting on out_stall holds the block in its hand-off step.
module chained_hash_map_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  chm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output chm_pkg::out_item_t  out_data
);
  import chm_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HEAD  = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  in_item_t         item_r;
  head_t            head_r;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BKT_W-1:0] clr_r, clr_nxt;
  out_item_t        res_r, res_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             in_acc;
  logic             resolve, hit, key_eq;
  head_t            old_head;
  logic             head_we;
  logic [BKT_W-1:0] head_waddr, head_raddr;
  logic [$bits(head_t)-1:0] head_wdata, head_rdata;
  logic             ent_we;
  logic [IDX_W-1:0] ent_waddr, ent_raddr;
  logic [$bits(entry_t)-1:0] ent_wdata, ent_rdata;
  head_t            head_rd;
  entry_t           ent_rd, ent_new;

  chm_ram #(.WIDTH($bits(head_t)), .DEPTH(BUCKETS)) u_heads (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  chm_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_entries (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign head_rd   = head_t'(head_rdata);
  assign ent_rd    = entry_t'(ent_rdata);
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign key_eq    = (ent_rd.key == item_r.key);
  assign old_head  = (state_r == ST_HEAD) ? head_rd : head_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequence the clear, head read, chain walk and resolve
  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    clr_nxt    = clr_r;
    res_nxt    = res_r;
    resolve    = 1'b0;
    hit        = 1'b0;
    head_we    = 1'b0;
    head_waddr = item_r.key[BKT_W-1:0];
    head_wdata = '0;
    head_raddr = in_data.key[BKT_W-1:0];
    ent_we     = 1'b0;
    ent_waddr  = cur_r;
    ent_raddr  = cur_r;
    ent_new    = ent_rd;
    unique case (state_r)
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == BKT_W'(BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (head_rd.ok) begin
          ent_raddr = head_rd.idx;
          cur_nxt   = head_rd.idx;
          state_nxt = ST_WALK;
        end else begin
          resolve = 1'b1;
        end
      end
      ST_WALK: begin
        if (key_eq) begin
          resolve = 1'b1;
          hit     = 1'b1;
        end else if (ent_rd.link_ok) begin
          ent_raddr = ent_rd.link;
          cur_nxt   = ent_rd.link;
        end else begin
          resolve = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Resolve: update the memories and build the result
    if (resolve) begin
      state_nxt         = ST_EMIT;
      res_nxt.found     = hit;
      res_nxt.value_out = (hit && item_r.cmd == CMD_FIND) ?
                          OUT_VAL_W'(ent_rd.value) : '0;
      res_nxt.inserted  = 1'b0;
      res_nxt.pool_full = 1'b0;
      if (item_r.cmd == CMD_PUT) begin
        if (hit) begin
          ent_new.value = item_r.value_in;
          ent_we        = 1'b1;
          ent_waddr     = cur_r;
        end else if (cnt_r >= CNT_W'(ENTRIES)) begin
          res_nxt.pool_full = 1'b1;
        end else begin
          ent_new.key      = item_r.key;
          ent_new.value    = item_r.value_in;
          ent_new.link_ok  = old_head.ok;
          ent_new.link     = old_head.idx;
          ent_we           = 1'b1;
          ent_waddr        = cnt_r[IDX_W-1:0];
          head_we          = 1'b1;
          head_wdata       = {1'b1, cnt_r[IDX_W-1:0]};
          cnt_nxt          = cnt_r + 1'b1;
          res_nxt.inserted = 1'b1;
        end
      end
      res_nxt.entries_used = ENT_USED_W'(cnt_nxt);
    end
    ent_wdata = ent_new;
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= (state_r == ST_EMIT);
      end
    end
  end

  // Hold the item, walk position, old head and pending result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    if (state_r == ST_HEAD) begin
      head_r <= head_rd;
    end
    cur_r <= cur_nxt;
    res_r <= res_nxt;
    if (!out_valid_r || !out_stall) begin
      out_data_r <= res_r;
    end
  end

  // Entry count never passes the pool size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ENTRIES))
    else $error("entry count beyond pool size");

  // An insert raises the count by exactly one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLEAR && head_we) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not raise entry count");

  // No item is taken during the clearing pass
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("item accepted while clearing heads");

  // A new result is only loaded after the previous one left
  a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && out_stall) |=> (state_r == ST_EMIT))
    else $error("result dropped while output stalled");

endmodule

[verif/tb.sv]
module tb;
  import chm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int HOT_BUCKETS = 8;
  localparam int TAIL_CYCLES = 64;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  chained_hash_map_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Shadow copy of the map
  logic             chain_head_ok [BUCKETS];
  logic [IDX_W-1:0] chain_head    [BUCKETS];
  logic [KEY_WIDTH-1:0]  pool_key     [ENTRIES];
  logic [DATA_WIDTH-1:0] pool_data    [ENTRIES];
  logic [IDX_W-1:0]      pool_link    [ENTRIES];
  logic                  pool_link_ok [ENTRIES];
  logic [CNT_W-1:0]      pool_used;

  // Item generation bookkeeping
  in_item_t              pending_ops[$];
  out_item_t             expected_results[$];
  bit                    key_seen[logic [KEY_WIDTH-1:0]];
  logic [KEY_WIDTH-1:0]  put_keys[$];
  int                    ops_in_flight = 0;

  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  int phase          = 0;
  int error_count    = 0;
  int results_seen   = 0;
  int hold_left      = 0;
  bit long_hold_done = 1'b0;
  int cycle_count    = 0;

  // Walk the chain of the key's bucket, then apply the find or the put
  function automatic out_item_t apply_map_op(in_item_t op);
    logic [BKT_W-1:0] bkt;
    logic             walk_ok;
    logic [IDX_W-1:0] walk_idx;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    int               steps;
    out_item_t        res;
    bkt      = op.key[BKT_W-1:0];
    walk_ok  = chain_head_ok[bkt];
    walk_idx = chain_head[bkt];
    hit      = 1'b0;
    hit_idx  = '0;
    steps    = 0;
    res      = '0;
    while (walk_ok && !hit && steps < ENTRIES) begin
      if (pool_key[walk_idx] == op.key) begin
        hit     = 1'b1;
        hit_idx = walk_idx;
      end else begin
        walk_ok  = pool_link_ok[walk_idx];
        walk_idx = pool_link[walk_idx];
        steps++;
      end
    end
    if (op.cmd == CMD_FIND) begin
      if (hit) begin
        res.found     = 1'b1;
        res.value_out = pool_data[hit_idx];
      end
    end else if (hit) begin
      res.found          = 1'b1;
      pool_data[hit_idx] = op.value_in;
    end else if (pool_used >= ENTRIES) begin
      res.pool_full = 1'b1;
    end else begin
      // push the new entry at the head of the chain
      pool_key[pool_used[IDX_W-1:0]]     = op.key;
      pool_data[pool_used[IDX_W-1:0]]    = op.value_in;
      pool_link[pool_used[IDX_W-1:0]]    = chain_head[bkt];
      pool_link_ok[pool_used[IDX_W-1:0]] = chain_head_ok[bkt];
      chain_head[bkt]    = pool_used[IDX_W-1:0];
      chain_head_ok[bkt] = 1'b1;
      pool_used          = pool_used + 1'b1;
      res.inserted       = 1'b1;
    end
    res.entries_used = ENT_USED_W'(pool_used);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH result %0d: %s", results_seen, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic push_op(logic cmd, logic [KEY_WIDTH-1:0] key,
                         logic [DATA_WIDTH-1:0] value);
    in_item_t op;
    op.cmd      = cmd;
    op.key      = key;
    op.value_in = value;
    if (cmd == CMD_PUT && !key_seen.exists(key)) begin
      key_seen[key] = 1'b1;
      put_keys.push_back(key);
    end
    pending_ops.push_back(op);
    ops_in_flight++;
  endtask

  // Extremes now and then, otherwise any word
  function automatic logic [DATA_WIDTH-1:0] random_data();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return DATA_WIDTH'($urandom);
  endfunction

  // Pick a key never put before; some land in a few crowded buckets
  function automatic logic [KEY_WIDTH-1:0] fresh_key();
    logic [KEY_WIDTH-1:0] k;
    do begin
      k = KEY_WIDTH'($urandom);
      if ($urandom_range(99) < 15)
        k[BKT_W-1:0] = BKT_W'($urandom_range(HOT_BUCKETS - 1));
    end while (key_seen.exists(k));
    return k;
  endfunction

  task automatic queue_random_op(int fresh_pct);
    int                   pick;
    logic [KEY_WIDTH-1:0] k;
    pick = $urandom_range(99);
    if (pick < fresh_pct || put_keys.size() == 0) begin
      push_op(CMD_PUT, fresh_key(), random_data());
    end else begin
      k = put_keys[$urandom_range(put_keys.size() - 1)];
      case ($urandom_range(3))
        0: push_op(CMD_PUT, k, random_data());
        1, 2: push_op(CMD_FIND, k, random_data());
        default: begin
          // likely absent, but shares a bucket with a stored key
          k[KEY_WIDTH-1:BKT_W] = (KEY_WIDTH - BKT_W)'($urandom);
          push_op(CMD_FIND, k, random_data());
        end
      endcase
    end
  endtask

  // Hold until every queued item has been answered
  task automatic wait_for_drain();
    do @(negedge clk);
    while (ops_in_flight != 0 || expected_results.size() != 0);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer queued items; predict each one as it is accepted
  always @(posedge clk) begin
    logic slot_free;
    if (rst_n) begin
      slot_free = !in_valid || !in_stall;
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_map_op(in_data));
        ops_in_flight--;
      end
      if (slot_free) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_data  <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check accepted results and drive the receiver's stall
  always @(posedge clk) begin
    out_item_t want;
    logic      stall_next;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("found", 32'(out_data.found), 32'(want.found));
          check_field("value_out", out_data.value_out, want.value_out);
          check_field("inserted", 32'(out_data.inserted), 32'(want.inserted));
          check_field("pool_full", 32'(out_data.pool_full), 32'(want.pool_full));
          check_field("entries_used", 32'(out_data.entries_used),
                      32'(want.entries_used));
        end
        results_seen++;
      end
      // hold off once for a long stretch so the block backs up
      if (phase == 3 && !long_hold_done) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        stall_next = ($urandom_range(99) < rx_idle_pct);
      end
      out_stall <= stall_next;
    end
  end

  initial begin
    foreach (chain_head_ok[b]) chain_head_ok[b] = 1'b0;
    pool_used   = '0;
    tx_idle_pct = 11;
    rx_idle_pct = 75;
    phase       = 1;

    // Directed: empty chain, zero data, chain order, overwrite, extremes
    push_op(CMD_FIND, 32'h0000_0000, 32'hFFFF_FFFF);
    push_op(CMD_PUT,  32'h0000_0000, 32'h0000_0000);
    push_op(CMD_FIND, 32'h0000_0000, 32'hFFFF_FFFF);
    push_op(CMD_PUT,  32'h0000_0100, 32'hFFFF_FFFF);
    push_op(CMD_FIND, 32'h0000_0100, 32'h0000_0000);
    push_op(CMD_FIND, 32'h0000_0000, 32'h0000_0000);
    push_op(CMD_PUT,  32'h0000_0000, 32'h1234_5678);
    push_op(CMD_FIND, 32'h0000_0000, 32'h0000_0000);
    push_op(CMD_FIND, 32'h0000_0200, 32'h0000_0000);
    push_op(CMD_PUT,  32'hFFFF_FFFF, 32'hA5A5_A5A5);
    push_op(CMD_FIND, 32'hFFFF_FFFF, 32'h0000_0000);
    push_op(CMD_PUT,  32'hFFFF_FFFF, 32'h0000_0000);
    push_op(CMD_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(CMD_FIND, 32'hFFFF_FF00, 32'h0000_0000);
    push_op(CMD_PUT,  32'h8000_0000, 32'h8000_0000);
    push_op(CMD_FIND, 32'h7FFF_FFFF, 32'h0000_0000);
    push_op(CMD_FIND, 32'h8000_0000, 32'h0000_0000);
    push_op(CMD_PUT,  32'h5A5A_5A5A, 32'h5A5A_5A5A);
    push_op(CMD_FIND, 32'hA5A5_A5A5, 32'h0000_0000);

    repeat (150) queue_random_op(60);
    wait_for_drain();

    tx_idle_pct = 75;
    rx_idle_pct = 11;
    phase       = 2;
    repeat (150) queue_random_op(60);
    wait_for_drain();

    // Fill the pool past its end, then mix with it full
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    phase       = 3;
    while (put_keys.size() < ENTRIES + 8)
      push_op(CMD_PUT, fresh_key(), random_data());
    repeat (100) queue_random_op(30);
    wait_for_drain();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
